// ===== src/crt_pkg.sv =====
`timescale 1ns / 1ps

package crt_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_CHUNK_ID   = 2'd0,
    CMD_CHUNK_ANON = 2'd1,
    CMD_TICK       = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  // Transfer status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_DECODING = 2'd1,
    ST_READY    = 2'd2,
    ST_EXPIRED  = 2'd3
  } status_t;

  // Image format codes
  localparam logic [1:0] KIND_JPEG   = 2'd0;
  localparam logic [1:0] KIND_RGB565 = 2'd1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_KIND     = 4'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] chunk_bytes;
    logic [7:0]  chunk_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        overflow;
    logic        complete;
    logic        start_decode;
    logic        load_bitmap;
    logic [23:0] bytes_so_far;
    logic [15:0] chunks_so_far;
    logic        timed_out;
  } out_item_t;

  typedef struct packed {
    logic [23:0] total_bytes;
    logic [7:0]  expected_count;
    logic [15:0] timeout_ticks;
    logic [1:0]  image_kind;
  } cfg_t;

endpackage

// ===== src/crt_cfg_regs.sv =====
`timescale 1ns / 1ps

module crt_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [crt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  wr_data,
  output crt_pkg::cfg_t                    cfg
);

  // Write the addressed register; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_bytes    <= '0;
      cfg.expected_count <= '0;
      cfg.timeout_ticks  <= crt_pkg::TIMEOUT_RESET;
      cfg.image_kind     <= crt_pkg::KIND_JPEG;
    end else if (wr_en) begin
      unique case (wr_index)
        crt_pkg::REG_TOTAL_BYTES:    cfg.total_bytes    <= wr_data;
        crt_pkg::REG_EXPECTED_COUNT: cfg.expected_count <= wr_data[7:0];
        crt_pkg::REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= wr_data[15:0];
        crt_pkg::REG_IMAGE_KIND:     cfg.image_kind     <= wr_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/crt_core.sv =====
`timescale 1ns / 1ps

module crt_core #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  crt_pkg::in_item_t   item,
  input  crt_pkg::cfg_t       cfg,
  output crt_pkg::out_item_t  result
);

  localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [MAX_CHUNKS-1:0] seen_map, seen_map_next;
  logic [8:0]            distinct_seen, distinct_seen_next;
  logic [23:0]           byte_count, byte_count_next;
  logic [15:0]           accepted_count, accepted_count_next;
  logic [15:0]           elapsed_ms, elapsed_ms_next;
  logic                  timer_running, timer_running_next;
  crt_pkg::status_t      status_reg, status_reg_next;

  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic [24:0]           byte_sum;
  logic                  all_marked_now;
  logic                  all_marked_new;
  logic [15:0]           elapsed_inc;

  assign idx      = item.chunk_index[IDX_W-1:0];
  assign in_range = ({1'b0, item.chunk_index} < {1'b0, cfg.expected_count}) &&
                    (32'(item.chunk_index) < MAX_CHUNKS);
  assign byte_sum = {1'b0, byte_count} + 25'(item.chunk_bytes);
  assign all_marked_now = distinct_seen >= {1'b0, cfg.expected_count};
  assign elapsed_inc = (elapsed_ms < crt_pkg::COUNT_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;

  // Work out the next state and the result of the current item
  always_comb begin
    seen_map_next       = seen_map;
    distinct_seen_next  = distinct_seen;
    byte_count_next     = byte_count;
    accepted_count_next = accepted_count;
    elapsed_ms_next     = elapsed_ms;
    timer_running_next  = timer_running;
    status_reg_next     = status_reg;
    all_marked_new      = all_marked_now;
    result              = '0;

    unique case (crt_pkg::cmd_t'(item.cmd))
      crt_pkg::CMD_CHUNK_ID, crt_pkg::CMD_CHUNK_ANON: begin
        // Mark the id first, even when the chunk is refused later
        if (item.cmd == crt_pkg::CMD_CHUNK_ID && in_range) begin
          if (!seen_map[idx]) begin
            seen_map_next[idx] = 1'b1;
            distinct_seen_next = distinct_seen + 9'd1;
          end
          if (!timer_running) begin
            timer_running_next = 1'b1;
            elapsed_ms_next    = '0;
          end
        end
        all_marked_new = distinct_seen_next >= {1'b0, cfg.expected_count};

        if (byte_sum > {1'b0, cfg.total_bytes}) begin
          // Refuse a chunk that would exceed the image size
          result.overflow = 1'b1;
          status_reg_next = crt_pkg::ST_EXPIRED;
        end else begin
          byte_count_next = byte_sum[23:0];
          if (accepted_count < crt_pkg::COUNT_MAX) begin
            accepted_count_next = accepted_count + 16'd1;
          end
          if (byte_sum[23:0] == cfg.total_bytes ||
              (item.cmd == crt_pkg::CMD_CHUNK_ID && all_marked_new)) begin
            result.complete = 1'b1;
            priority if (cfg.image_kind == crt_pkg::KIND_JPEG) begin
              result.start_decode = 1'b1;
              status_reg_next     = crt_pkg::ST_DECODING;
            end else if (cfg.image_kind == crt_pkg::KIND_RGB565) begin
              result.load_bitmap = 1'b1;
              status_reg_next    = crt_pkg::ST_READY;
            end else begin
              status_reg_next = crt_pkg::ST_EXPIRED;
            end
          end
        end
      end
      crt_pkg::CMD_TICK: begin
        // Advance the timer and expire an incomplete transfer
        if (timer_running) begin
          elapsed_ms_next = elapsed_inc;
          if (!all_marked_now && elapsed_inc >= cfg.timeout_ticks) begin
            result.timed_out = 1'b1;
            status_reg_next  = crt_pkg::ST_EXPIRED;
          end
        end
      end
      default: ;
    endcase

    result.status        = status_reg_next;
    result.bytes_so_far  = byte_count_next;
    result.chunks_so_far = accepted_count_next;
  end

  // Commit the state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_map       <= '0;
      distinct_seen  <= '0;
      byte_count     <= '0;
      accepted_count <= '0;
      elapsed_ms     <= '0;
      timer_running  <= 1'b0;
      status_reg     <= crt_pkg::ST_NONE;
    end else if (step) begin
      seen_map       <= seen_map_next;
      distinct_seen  <= distinct_seen_next;
      byte_count     <= byte_count_next;
      accepted_count <= accepted_count_next;
      elapsed_ms     <= elapsed_ms_next;
      timer_running  <= timer_running_next;
      status_reg     <= status_reg_next;
    end
  end

endmodule

// ===== src/chunk_reassembly_tracker_unit.sv =====
`timescale 1ns / 1ps

// Chunk reassembly tracker. Each transfer on the input channel is a chunk
// arrival (with or without an id) or a one millisecond tick, and yields
// exactly one result transfer carrying the transfer status, per-item flags
// and the running byte and chunk counts. An item passes an input register
// and then the update logic into an output register, so the block
// sustains one item per cycle while the output is not stalled; a stalled
// output holds the pipeline. The received map is a MAX_CHUNKS-bit flip-flop
// vector cleared by reset, so no clearing pass is needed. Configuration
// writes are taken in any cycle and must only be issued while the block is
// idle.
module chunk_reassembly_tracker_unit #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  crt_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output crt_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  crt_pkg::cfg_t      cfg;
  crt_pkg::in_item_t  stage_item;
  logic               stage_valid;
  logic               stage_advance;
  crt_pkg::out_item_t core_result;

  assign cfg_ready = 1'b1;

  crt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the staged item when the output register is free or draining
  assign stage_advance = stage_valid && (!out_valid || out_ready);
  assign in_ready      = !stage_valid || stage_advance;

  // Hold the accepted item in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  crt_core #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (stage_advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // Load the result register; drop valid once the result transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      out_data <= core_result;
    end
  end

  // A refused chunk always leaves the transfer expired and never completes it
  a_overflow_expires: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.status == crt_pkg::ST_EXPIRED && !out_data.complete)
    else $error("overflow result without expired status");

  // A decode request comes only with completion and decoding status
  a_decode_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.start_decode |->
      out_data.complete && out_data.status == crt_pkg::ST_DECODING)
    else $error("start_decode without completion");

  // Input stalls only while an item waits behind a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && out_valid && !out_ready)
    else $error("input stalled without back pressure");

endmodule

// ===== bench/tb_chunk_reassembly_tracker_unit.sv =====
`timescale 1ns / 1ps

module tb_chunk_reassembly_tracker_unit;
  import crt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAP_DEPTH   = 256;
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1130;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    bit                    pinned;
    out_item_t             want;
  } step_row_t;

  typedef struct {
    bit        pinned;
    out_item_t want;
  } pin_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Tracker mirror: received map, counters, timer and status
  logic [MAP_DEPTH-1:0] seen_ids;
  logic [8:0]  marked_total;
  logic [23:0] byte_total;
  logic [15:0] chunk_total;
  logic [15:0] ms_elapsed;
  logic        timer_on;
  status_t     cur_status;

  // Register mirror
  logic [23:0] size_limit;
  logic [7:0]  chunk_goal;
  logic [15:0] ms_limit;
  logic [1:0]  img_kind;

  out_item_t due_reports[$];
  pin_t      pins_q[$];
  step_row_t steps[$];

  out_item_t guess;
  out_item_t due;
  pin_t      pin;

  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int sent_items = 0;
  int checked = 0;
  int completions = 0;
  int refusals = 0;
  int timeouts = 0;
  int quiet_cycles = 0;
  int directed_n;
  int phase_no;
  bit prev_write;

  chunk_reassembly_tracker_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit map_full();
    return marked_total >= {1'b0, chunk_goal};
  endfunction

  // Advance the mirror by one item and return the report it should produce
  function automatic out_item_t track_item(in_item_t it);
    out_item_t r;
    logic [24:0] sum;
    r = '0;
    case (cmd_t'(it.cmd))
      CMD_CHUNK_ID, CMD_CHUNK_ANON: begin
        // mark the id first, even if the chunk is refused below
        if (it.cmd == CMD_CHUNK_ID && it.chunk_index < chunk_goal
            && int'(it.chunk_index) < MAP_DEPTH) begin
          if (!seen_ids[it.chunk_index]) begin
            seen_ids[it.chunk_index] = 1'b1;
            marked_total = marked_total + 9'd1;
          end
          if (!timer_on) begin
            timer_on = 1'b1;
            ms_elapsed = '0;
          end
        end
        sum = {1'b0, byte_total} + {9'd0, it.chunk_bytes};
        if (sum > {1'b0, size_limit}) begin
          r.overflow = 1'b1;
          cur_status = ST_EXPIRED;
        end else begin
          byte_total = sum[23:0];
          if (chunk_total != COUNT_MAX) chunk_total = chunk_total + 16'd1;
          if (byte_total == size_limit || (it.cmd == CMD_CHUNK_ID && map_full())) begin
            r.complete = 1'b1;
            if (img_kind == KIND_JPEG) begin
              r.start_decode = 1'b1;
              cur_status = ST_DECODING;
            end else if (img_kind == KIND_RGB565) begin
              r.load_bitmap = 1'b1;
              cur_status = ST_READY;
            end else begin
              cur_status = ST_EXPIRED;
            end
          end
        end
      end
      CMD_TICK: begin
        if (timer_on) begin
          if (ms_elapsed != COUNT_MAX) ms_elapsed = ms_elapsed + 16'd1;
          if (!map_full() && ms_elapsed >= ms_limit) begin
            r.timed_out = 1'b1;
            cur_status = ST_EXPIRED;
          end
        end
      end
      default: ;
    endcase
    r.status = cur_status;
    r.bytes_so_far = byte_total;
    r.chunks_so_far = chunk_total;
    return r;
  endfunction

  function automatic out_item_t report(status_t st, bit ovf, bit done, bit dec, bit load,
                                       logic [23:0] nbytes, logic [15:0] nchunks, bit tmo);
    out_item_t r;
    r.status = st;
    r.overflow = ovf;
    r.complete = done;
    r.start_decode = dec;
    r.load_bitmap = load;
    r.bytes_so_far = nbytes;
    r.chunks_so_far = nchunks;
    r.timed_out = tmo;
    return r;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    step_row_t row;
    row.is_write = 1'b1;
    row.addr = addr;
    row.wdata = wdata;
    row.item = '0;
    row.pinned = 1'b0;
    row.want = '0;
    steps = {steps, row};
  endfunction

  function automatic void add_item(cmd_t cmd, logic [15:0] len, logic [7:0] idx,
                                   bit pinned = 1'b0, out_item_t want = '0);
    step_row_t row;
    row.is_write = 1'b0;
    row.addr = '0;
    row.wdata = '0;
    row.item.cmd = cmd;
    row.item.chunk_bytes = len;
    row.item.chunk_index = idx;
    row.pinned = pinned;
    row.want = want;
    steps = {steps, row};
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_len();
    if ($urandom_range(0, 29) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 1500));
  endfunction

  // Offer one item and hold it until the transfer; valid stays high afterwards
  task automatic push_item(in_item_t it, bit pinned = 1'b0, out_item_t want = '0);
    pin_t p;
    int gap;
    p.pinned = pinned;
    p.want = want;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pins_q = {pins_q, p};
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= addr;
    cfg_data <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One image: program the registers from the mirror, then send its chunks
  task automatic run_phase(bit squeeze);
    in_item_t plan[$];
    int open_ids[$];
    in_item_t it;
    int goal, wanted, ticks, r, k;
    longint spend, lim, tmo;
    logic [1:0] kind;
    spend = 0;
    ticks = 0;
    goal = int'(marked_total) + $urandom_range(1, 12);
    if (goal > 255) goal = 255;
    if ($urandom_range(0, 9) == 0) goal = $urandom_range(0, 255);
    for (k = 0; k < goal; k++) begin
      if (!seen_ids[8'(k)]) open_ids = {open_ids, k};
    end
    open_ids.shuffle();
    wanted = (open_ids.size() > 24) ? 24 : open_ids.size();
    // leave one id out now and then so the map stays incomplete
    if (wanted > 0 && $urandom_range(0, 3) == 0) wanted--;
    for (k = 0; k < wanted || (squeeze && plan.size() < 30); k++) begin
      r = $urandom_range(0, 99);
      it.cmd = CMD_UNUSED;
      it.chunk_bytes = pick_len();
      it.chunk_index = 8'($urandom_range(0, 255));
      if (r < 22) begin
        it.cmd = CMD_TICK;
        ticks++;
      end else if (r < 40) begin
        it.cmd = CMD_CHUNK_ANON;
      end else if (r < 46) begin
        // id within the announced count, or one at or beyond it
        it.cmd = CMD_CHUNK_ID;
        if (goal > 0 && $urandom_range(0, 1) == 1)
          it.chunk_index = 8'($urandom_range(0, goal - 1));
        else
          it.chunk_index = 8'($urandom_range(goal, 255));
      end
      if (r < 49) begin
        if (it.cmd == CMD_CHUNK_ID || it.cmd == CMD_CHUNK_ANON) spend += it.chunk_bytes;
        plan = {plan, it};
      end
      if (k < wanted) begin
        it.cmd = CMD_CHUNK_ID;
        it.chunk_bytes = pick_len();
        it.chunk_index = 8'(open_ids[k]);
        spend += it.chunk_bytes;
        plan = {plan, it};
      end
    end
    repeat ($urandom_range(0, 6)) begin
      it.cmd = CMD_TICK;
      it.chunk_bytes = pick_len();
      it.chunk_index = 8'($urandom_range(0, 255));
      ticks++;
      plan = {plan, it};
    end

    // size budget: exact, loose, short (refusals) or unrelated
    case ($urandom_range(0, 3))
      0: lim = byte_total + spend;
      1: lim = byte_total + spend + $urandom_range(1, 4000);
      2: lim = byte_total + spend - $urandom_range(0, int'(spend));
      default: lim = byte_total + $urandom_range(0, 2000);
    endcase
    if (lim > 64'hFF_FFFF) lim = 64'hFF_FFFF;
    tmo = (timer_on ? ms_elapsed : 0) + $urandom_range(0, ticks + 2);
    if ($urandom_range(0, 9) == 0) tmo = ($urandom_range(0, 1) == 1) ? 0 : 65535;
    if (tmo > 65535) tmo = 65535;
    kind = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));

    write_reg(REG_TOTAL_BYTES, lim[23:0]);
    write_reg(REG_EXPECTED_COUNT, 24'(goal));
    write_reg(REG_TIMEOUT_TICKS, {8'd0, tmo[15:0]});
    write_reg(REG_IMAGE_KIND, {22'd0, kind});
    cfg_valid <= 1'b0;

    no_idle = squeeze || ($urandom_range(0, 4) == 0);
    if (squeeze) hold_req = 1'b1;
    foreach (plan[i]) push_item(plan[i]);
    drain();
  endtask

  // Mirror register writes, predict accepted items, check result transfers
  always @(posedge clk) begin
    if (rst) begin
      seen_ids = '0;
      marked_total = '0;
      byte_total = '0;
      chunk_total = '0;
      ms_elapsed = '0;
      timer_on = 1'b0;
      cur_status = ST_NONE;
      size_limit = '0;
      chunk_goal = '0;
      ms_limit = TIMEOUT_RESET;
      img_kind = KIND_JPEG;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_BYTES:    size_limit = cfg_data[23:0];
          REG_EXPECTED_COUNT: chunk_goal = cfg_data[7:0];
          REG_TIMEOUT_TICKS:  ms_limit = cfg_data[15:0];
          REG_IMAGE_KIND:     img_kind = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        guess = track_item(in_data);
        if (pins_q.size() != 0) begin
          pin = pins_q.pop_front();
          if (pin.pinned) guess = pin.want;
        end
        due_reports = {due_reports, guess};
      end
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          $error("result transfer with nothing pending: status %0d, bytes 0x%0h",
                 out_data.status, out_data.bytes_so_far);
          mismatches++;
        end else begin
          due = due_reports.pop_front();
          check_field("status", 24'(due.status), 24'(out_data.status));
          check_field("overflow", 24'(due.overflow), 24'(out_data.overflow));
          check_field("complete", 24'(due.complete), 24'(out_data.complete));
          check_field("start_decode", 24'(due.start_decode), 24'(out_data.start_decode));
          check_field("load_bitmap", 24'(due.load_bitmap), 24'(out_data.load_bitmap));
          check_field("bytes_so_far", due.bytes_so_far, out_data.bytes_so_far);
          check_field("chunks_so_far", 24'(due.chunks_so_far), 24'(out_data.chunks_so_far));
          check_field("timed_out", 24'(due.timed_out), 24'(out_data.timed_out));
          checked++;
          if (due.complete) completions++;
          if (due.overflow) refusals++;
          if (due.timed_out) timeouts++;
        end
      end
    end
  end

  // Stop a hung run: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports pending",
               quiet_cycles, due_reports.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        out_ready <= 1'b0;
        repeat ((stall > 0) ? stall : 1) @(posedge clk);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;

    // Directed rows, starting from reset registers
    add_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1,
             report(ST_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 1'b0));
    add_item(CMD_TICK, 16'd0, 8'd0, 1'b1,
             report(ST_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 24'd0, 16'd0, 1'b0));
    add_item(CMD_CHUNK_ANON, 16'd0, 8'd0, 1'b1,
             report(ST_DECODING, 1'b0, 1'b1, 1'b1, 1'b0, 24'd0, 16'd1, 1'b0));
    add_item(CMD_CHUNK_ID, 16'd1, 8'd0, 1'b1,
             report(ST_EXPIRED, 1'b1, 1'b0, 1'b0, 1'b0, 24'd0, 16'd1, 1'b0));
    add_item(CMD_CHUNK_ANON, 16'hFFFF, 8'd0, 1'b1,
             report(ST_EXPIRED, 1'b1, 1'b0, 1'b0, 1'b0, 24'd0, 16'd1, 1'b0));
    add_write(REG_TOTAL_BYTES, 24'hFF_FFFF);
    add_write(REG_EXPECTED_COUNT, 24'd255);
    add_write(REG_TIMEOUT_TICKS, 24'd0);
    add_write(REG_IMAGE_KIND, {22'd0, KIND_RGB565});
    add_item(CMD_CHUNK_ID, 16'hFFFF, 8'hFF, 1'b1,
             report(ST_EXPIRED, 1'b0, 1'b0, 1'b0, 1'b0, 24'h00FFFF, 16'd2, 1'b0));
    add_item(CMD_TICK, 16'd0, 8'd0, 1'b1,
             report(ST_EXPIRED, 1'b0, 1'b0, 1'b0, 1'b0, 24'h00FFFF, 16'd2, 1'b0));
    add_item(CMD_CHUNK_ID, 16'd0, 8'hFE, 1'b1,
             report(ST_EXPIRED, 1'b0, 1'b0, 1'b0, 1'b0, 24'h00FFFF, 16'd3, 1'b0));
    add_item(CMD_TICK, 16'd0, 8'd0, 1'b1,
             report(ST_EXPIRED, 1'b0, 1'b0, 1'b0, 1'b0, 24'h00FFFF, 16'd3, 1'b1));
    add_item(CMD_CHUNK_ID, 16'hAAAA, 8'hFE);
    add_write(REG_EXPECTED_COUNT, 24'd2);
    add_write(REG_TIMEOUT_TICKS, 24'h00FFFF);
    add_item(CMD_CHUNK_ID, 16'h5555, 8'h00);
    add_item(CMD_TICK, 16'h1234, 8'h5A);
    add_write(REG_TOTAL_BYTES, 24'h020062);
    add_write(REG_EXPECTED_COUNT, 24'd200);
    add_write(REG_IMAGE_KIND, 24'd2);
    add_item(CMD_CHUNK_ANON, 16'd100, 8'h5A);
    add_item(CMD_CHUNK_ANON, 16'd1, 8'd0, 1'b1,
             report(ST_EXPIRED, 1'b1, 1'b0, 1'b0, 1'b0, 24'h020062, 16'd6, 1'b0));
    add_write(REG_TOTAL_BYTES, 24'hFF_FFFF);
    add_write(REG_IMAGE_KIND, 24'd3);
    add_item(CMD_CHUNK_ID, 16'd0, 8'h7F);
    add_item(CMD_TICK, 16'd0, 8'd0);
    add_write(REG_EXPECTED_COUNT, 24'd0);
    add_write(REG_IMAGE_KIND, {22'd0, KIND_JPEG});
    add_item(CMD_CHUNK_ID, 16'd1, 8'h80);
    add_item(CMD_CHUNK_ANON, 16'h8001, 8'h01);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; registers change only once the block has drained
    prev_write = 1'b0;
    foreach (steps[i]) begin
      if (steps[i].is_write) begin
        if (!prev_write) drain();
        write_reg(steps[i].addr, steps[i].wdata);
      end else begin
        if (prev_write) cfg_valid <= 1'b0;
        push_item(steps[i].item, steps[i].pinned, steps[i].want);
      end
      prev_write = steps[i].is_write;
    end
    drain();
    directed_n = sent_items;

    // Random images until the item budget is spent
    phase_no = 0;
    while (sent_items < directed_n + RANDOM_ITEMS) begin
      run_phase(phase_no == 3);
      phase_no++;
    end

    $display("run: %0d items over %0d random images after %0d directed, %0d reports checked",
             sent_items, phase_no, directed_n, checked);
    $display("run: %0d completions, %0d refused chunks, %0d timeouts, %0d ids marked",
             completions, refusals, timeouts, marked_total);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
